>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/avsr_pkg.sv
`default_nettype none
package avsr_pkg;

  // Field widths
  localparam int COUNT_W = 8;
  localparam int RPM_W   = 14;
  localparam int DUTY_W  = 10;
  localparam int STEP_W  = 8;
  localparam int BAND_LOW_W = 16;
  localparam int SUM_W   = 22;
  localparam int CFG_DATA_W = 16;

  // Arithmetic constants
  localparam int RPM_PER_COUNT = 60;
  localparam logic [DUTY_W-1:0] DUTY_CEIL = 10'd1022;
  localparam logic [RPM_W-1:0]  AVG_MAX   = 14'd16383;

  // t / 100 as (t * 5243) >> 19, exact for 14-bit t
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIV100_Q_W   = 8;
  localparam int DIV100_P_W   = DIV100_SHIFT + DIV100_Q_W;

  // Serial divider
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [COUNT_W-1:0] rotation_count;
    logic [RPM_W-1:0]   target_rpm;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic [RPM_W-1:0]  average_rpm;
    logic              in_tolerance;
    logic              updated;
  } result_t;

  typedef enum logic [2:0] {
    REG_TOLERANCE  = 3'd0,
    REG_PERIODS    = 3'd1,
    REG_STEP_TRACK = 3'd2,
    REG_STEP_MID   = 3'd3,
    REG_STEP_HIGH  = 3'd4,
    REG_STEP_LOW   = 3'd5,
    REG_BAND_HIGH  = 3'd6,
    REG_BAND_LOW   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_CORR1,
    S_CORR2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/averaged_speed_step_regulator_core.sv
// Channel   Direction  Handshake              Payload
// sample    in         sample_valid/stall     avsr_pkg::sample_t
// result    out        result_valid/stall     avsr_pkg::result_t
// config    in         cfg_write              cfg_index, cfg_data
//
// From accept to next accept, accumulating passes idle, evaluate and done;
// averaging passes idle, evaluate, 22 restoring divider steps for sum /
// periods_per_update, CORR1, CORR2, done; a zero period count skips the divider.
// rst is synchronous, active high; no clearing pass is needed.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits in its last cycle until the register frees.
`default_nettype none
`include "assert_macros.svh"
module averaged_speed_step_regulator_core #(
  parameter int INITIAL_PWM  = 64,
  parameter int RAMP_PERCENT = 50
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  sample_valid,
  output logic                                 sample_stall,
  input  avsr_pkg::sample_t                    sample,
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output avsr_pkg::result_t                    result,
  input  wire                                  cfg_write,
  input  avsr_pkg::cfg_reg_t                   cfg_index,
  input  wire [avsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import avsr_pkg::*;

  localparam int SPEED_W = RPM_W;
  localparam int RAMP_W  = RPM_W;

  // Configuration registers
  logic [STEP_W-1:0]     tolerance_rpm;
  logic [COUNT_W-1:0]    periods_per_update;
  logic [STEP_W-1:0]     step_tracking;
  logic [STEP_W-1:0]     step_middle;
  logic [STEP_W-1:0]     step_high;
  logic [STEP_W-1:0]     step_low;
  logic [RPM_W-1:0]      band_high_rpm;
  logic [BAND_LOW_W-1:0] band_low_rpm;

  // Regulator state
  logic [DUTY_W-1:0]  duty;
  logic [SUM_W-1:0]   speed_sum;
  logic [COUNT_W-1:0] sample_count;
  logic [RPM_W-1:0]   deviation;
  logic [RPM_W-1:0]   last_average;

  // Work registers
  state_t                state, state_next;
  sample_t               cur;
  logic [SUM_W-1:0]      div_q;
  logic [COUNT_W-1:0]    div_rem;
  logic [DIV_CNT_W-1:0]  div_count;
  logic [DIV100_Q_W-1:0] tgt_div100;
  logic [RPM_W-1:0]      avg;
  logic [RPM_W-1:0]      dev_new;
  logic                  is_below, is_above, avg_lt_ramp;
  logic                  le_bh, ge_bh, le_bl, ge_bl;
  logic                  upd_flag;

  logic sample_take, result_free, is_accum, div_last;
  logic [SPEED_W-1:0]    speed;
  logic [DIV100_P_W-1:0] div100_prod;
  logic [COUNT_W:0]      rem_shift;
  logic                  rem_ge;
  logic [COUNT_W-1:0]    rem_next;
  logic [RPM_W-1:0]      avg_sat;
  logic [RAMP_W-1:0]     ramp;
  logic [STEP_W-1:0]     step;
  logic [DUTY_W:0]       duty_sum;
  logic [DUTY_W-1:0]     duty_new;
  logic                  dev_gt_tol, dev_ge_tol;

  assign sample_take = sample_valid && !sample_stall;
  assign result_free = !result_valid || !result_stall;
  assign is_accum    = (sample_count != periods_per_update);
  assign div_last    = (div_count == DIV_CNT_W'(DIV_STEPS - 1));

  // Speed and target / 100
  assign speed       = SPEED_W'(cur.rotation_count) * SPEED_W'(RPM_PER_COUNT);
  assign div100_prod = DIV100_P_W'(cur.target_rpm) * DIV100_P_W'(DIV100_MUL);

  // One restoring divider step
  assign rem_shift = {div_rem, div_q[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, periods_per_update});
  assign rem_next  = rem_ge ? COUNT_W'(rem_shift - {1'b0, periods_per_update})
                            : rem_shift[COUNT_W-1:0];

  // Quotient saturated to 14 bits; ramp threshold
  assign avg_sat = (div_q > SUM_W'(AVG_MAX)) ? AVG_MAX : div_q[RPM_W-1:0];
  assign ramp    = RAMP_W'(tgt_div100) * RAMP_W'(RAMP_PERCENT);

  // Step selection and duty update
  assign dev_gt_tol = (dev_new > RPM_W'(tolerance_rpm));
  assign dev_ge_tol = (dev_new >= RPM_W'(tolerance_rpm));

  always_comb begin
    step = '0;
    if (is_below) begin
      if (avg_lt_ramp) begin
        if (le_bh && ge_bl) step = step_middle;
        if (le_bh && le_bl) step = step_low;
        if (ge_bh && ge_bl) step = step_high;
      end else if (dev_gt_tol) begin
        step = step_tracking;
      end
    end else if (is_above) begin
      if (cur.target_rpm == '0) begin
        step = le_bl ? step_low : step_middle;
      end else if (dev_gt_tol) begin
        step = step_tracking;
      end
    end
  end

  always_comb begin
    duty_sum = {1'b0, duty} + (DUTY_W+1)'(step);
    duty_new = duty;
    if (is_below && dev_ge_tol) begin
      duty_new = (duty_sum > {1'b0, DUTY_CEIL}) ? DUTY_CEIL : duty_sum[DUTY_W-1:0];
    end else if (is_above && dev_ge_tol) begin
      duty_new = (duty > DUTY_W'(step)) ? duty - DUTY_W'(step) : '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sample_take) state_next = S_EVAL;
      S_EVAL: begin
        if (is_accum) state_next = S_DONE;
        else if (periods_per_update == '0) state_next = S_CORR1;
        else state_next = S_DIV;
      end
      S_DIV:   if (div_last) state_next = S_CORR1;
      S_CORR1: state_next = S_CORR2;
      S_CORR2: state_next = S_DONE;
      S_DONE:  if (result_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    sample_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_rpm      <= '0;
      periods_per_update <= COUNT_W'(1);
      step_tracking      <= '0;
      step_middle        <= '0;
      step_high          <= '0;
      step_low           <= '0;
      band_high_rpm      <= '0;
      band_low_rpm       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOLERANCE:  tolerance_rpm      <= cfg_data[STEP_W-1:0];
        REG_PERIODS:    periods_per_update <= cfg_data[COUNT_W-1:0];
        REG_STEP_TRACK: step_tracking      <= cfg_data[STEP_W-1:0];
        REG_STEP_MID:   step_middle        <= cfg_data[STEP_W-1:0];
        REG_STEP_HIGH:  step_high          <= cfg_data[STEP_W-1:0];
        REG_STEP_LOW:   step_low           <= cfg_data[STEP_W-1:0];
        REG_BAND_HIGH:  band_high_rpm      <= cfg_data[RPM_W-1:0];
        REG_BAND_LOW:   band_low_rpm       <= cfg_data[BAND_LOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      duty         <= DUTY_W'(INITIAL_PWM);
      speed_sum    <= '0;
      sample_count <= '0;
      deviation    <= '0;
      last_average <= '0;
    end else begin
      if (state == S_EVAL && is_accum) begin
        sample_count <= sample_count + COUNT_W'(1);
        speed_sum    <= speed_sum + SUM_W'(speed);
      end
      if (state == S_CORR2) begin
        duty         <= duty_new;
        last_average <= avg;
        if (is_below || is_above) deviation <= dev_new;
        speed_sum    <= '0;
        sample_count <= '0;
      end
    end
  end

  // Datapath work registers
  always_ff @(posedge clk) begin
    if (sample_take) cur <= sample;
    case (state)
      S_EVAL: begin
        upd_flag   <= !is_accum;
        tgt_div100 <= div100_prod[DIV100_P_W-1:DIV100_SHIFT];
        div_q      <= (periods_per_update == '0) ? '0 : speed_sum;
        div_rem    <= '0;
        div_count  <= '0;
      end
      S_DIV: begin
        div_q     <= {div_q[SUM_W-2:0], rem_ge};
        div_rem   <= rem_next;
        div_count <= div_count + DIV_CNT_W'(1);
      end
      S_CORR1: begin
        avg         <= avg_sat;
        is_below    <= (avg_sat < cur.target_rpm);
        is_above    <= (avg_sat > cur.target_rpm);
        dev_new     <= (avg_sat < cur.target_rpm) ? cur.target_rpm - avg_sat
                                                  : avg_sat - cur.target_rpm;
        avg_lt_ramp <= (avg_sat < ramp);
        le_bh       <= (avg_sat <= band_high_rpm);
        ge_bh       <= (avg_sat >= band_high_rpm);
        le_bl       <= (BAND_LOW_W'(avg_sat) <= band_low_rpm);
        ge_bl       <= (BAND_LOW_W'(avg_sat) >= band_low_rpm);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && result_free) begin
      result.pwm_duty     <= duty;
      result.average_rpm  <= last_average;
      result.in_tolerance <= (deviation <= RPM_W'(tolerance_rpm));
      result.updated      <= upd_flag;
    end
  end

  // Checks
  `ASSERT_CLK(a_duty_ceiling, clk, rst, duty <= DUTY_CEIL, "duty above ceiling")
  `ASSERT_CLK(a_accept_eval, clk, rst, sample_take |=> state == S_EVAL, "no evaluate")
  `ASSERT_CLK(a_rem_bound, clk, rst, state == S_DIV |-> div_rem < periods_per_update, "rem")
  `ASSERT_CLK(a_div_end, clk, rst, (state == S_DIV && div_last) |=> state == S_CORR1, "overran")
  `ASSERT_CLK(a_update_clears, clk, rst, state == S_CORR2 |=> speed_sum == '0, "sum kept")

endmodule
`default_nettype wire
